/* src/kwch_pkg.sv */
// Package for the k-mer window CRC-32 hasher: constants, types and the CRC byte step.
package kwch_pkg;

    localparam int MAX_WINDOW = 32;
    localparam int WIN_IDX_W  = $clog2(MAX_WINDOW);
    localparam int LEN_W      = 6;
    localparam int SYM_W      = 8;
    localparam int CRC_W      = 32;

    localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(16);
    localparam logic [LEN_W-1:0] LEN_MIN   = LEN_W'(1);
    localparam logic [LEN_W-1:0] LEN_MAX   = LEN_W'(MAX_WINDOW);

    localparam logic [CRC_W-1:0] CRC_POLY = 32'hEDB8_8320;
    localparam logic [CRC_W-1:0] CRC_INIT = 32'hFFFF_FFFF;
    localparam logic [CRC_W-1:0] CRC_XOUT = 32'hFFFF_FFFF;

    typedef struct packed {
        logic load;
        logic step;
        logic load_out;
    } kwch_cmd_t;

    typedef struct packed {
        logic hit;
        logic last_step;
    } kwch_sts_t;

    function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc_in,
                                                  input logic [SYM_W-1:0] data);
        logic [CRC_W-1:0] c;
        c = crc_in ^ {{(CRC_W-SYM_W){1'b0}}, data};
        for (int b = 0; b < SYM_W; b++)
        begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

endpackage

/* src/kwch_ctrl.sv */
// Controller for the k-mer window CRC-32 hasher: sequencing and output valid.
module kwch_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  kwch_pkg::kwch_sts_t sts,
    output kwch_pkg::kwch_cmd_t cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CRC,
        ST_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    assign out_free = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd            = '0;
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    if (sts.hit)
                        state_next = ST_CRC;
                end
            end
            ST_CRC:
            begin
                cmd.step = 1'b1;
                if (sts.last_step)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

/* src/kwch_dp.sv */
// Datapath for the k-mer window CRC-32 hasher: window, fill count, CRC unit, result register.
module kwch_dp (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [kwch_pkg::LEN_W-1:0]         cfg_wdata,
    input  logic [kwch_pkg::SYM_W-1:0]         symbol,
    input  logic                               end_of_sequence,
    output logic [kwch_pkg::CRC_W-1:0]         window_hash,
    output logic                               last_of_sequence,
    input  kwch_pkg::kwch_cmd_t                cmd,
    output kwch_pkg::kwch_sts_t                sts
);

    logic [kwch_pkg::SYM_W-1:0]     win_reg [kwch_pkg::MAX_WINDOW];
    logic [kwch_pkg::LEN_W-1:0]     len_reg;
    logic [kwch_pkg::LEN_W-1:0]     fill_reg;
    logic [kwch_pkg::LEN_W-1:0]     fill_inc;
    logic [kwch_pkg::LEN_W-1:0]     k_eff;
    logic [kwch_pkg::LEN_W-1:0]     start_idx;
    logic [kwch_pkg::LEN_W-1:0]     cnt_reg;
    logic [kwch_pkg::WIN_IDX_W-1:0] idx_reg;
    logic [kwch_pkg::CRC_W-1:0]     crc_reg;
    logic                           eos_reg;
    logic [kwch_pkg::CRC_W-1:0]     hash_reg;
    logic                           last_reg;

    always_comb
    begin
        priority if (len_reg < kwch_pkg::LEN_MIN)
            k_eff = kwch_pkg::LEN_MIN;
        else if (len_reg > kwch_pkg::LEN_MAX)
            k_eff = kwch_pkg::LEN_MAX;
        else
            k_eff = len_reg;
    end

    assign fill_inc  = (fill_reg < kwch_pkg::LEN_MAX) ? fill_reg + 1'b1 : fill_reg;
    assign start_idx = kwch_pkg::LEN_MAX - k_eff;

    assign sts.hit       = (fill_inc >= k_eff);
    assign sts.last_step = (cnt_reg == kwch_pkg::LEN_W'(1));

    assign window_hash      = hash_reg;
    assign last_of_sequence = last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg  <= kwch_pkg::LEN_RESET;
            fill_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            if (cfg_we)
                len_reg <= cfg_wdata;
            if (cmd.load)
            begin
                fill_reg <= end_of_sequence ? '0 : fill_inc;
                cnt_reg  <= k_eff;
            end
            else if (cmd.step)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

    // window bytes are only read once the fill count covers them
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            for (int i = 0; i < kwch_pkg::MAX_WINDOW - 1; i++)
            begin
                win_reg[i] <= win_reg[i+1];
            end
            win_reg[kwch_pkg::MAX_WINDOW-1] <= symbol;
            eos_reg <= end_of_sequence;
            idx_reg <= start_idx[kwch_pkg::WIN_IDX_W-1:0];
            crc_reg <= kwch_pkg::CRC_INIT;
        end
        else if (cmd.step)
        begin
            crc_reg <= kwch_pkg::crc_byte(crc_reg, win_reg[idx_reg]);
            idx_reg <= idx_reg + 1'b1;
        end
        if (cmd.load_out)
        begin
            hash_reg <= crc_reg ^ kwch_pkg::CRC_XOUT;
            last_reg <= eos_reg;
        end
    end

endmodule

/* src/kmer_window_crc32_hasher.sv */
// Top level of the k-mer window CRC-32 hasher.
//
//  channel | signals                                      | handshake
//  --------+----------------------------------------------+--------------------
//  config  | cfg_we, cfg_wdata[5:0] (shingle length)      | write when cfg_we
//  input   | symbol[7:0], end_of_sequence                 | in_valid / in_ready
//  output  | window_hash[31:0], last_of_sequence          | out_valid / out_ready
//
// An item that yields no hash leaves the controller in idle; for one that yields a hash, in_ready
// stays low while the CRC unit folds one window byte per cycle over the last K window bytes.
// Reset clears the fill count, output valid and sets the length to 16.
// The result register lets a new item enter while a hash waits; a finished CRC
// holds until that register is free.
module kmer_window_crc32_hasher (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [kwch_pkg::LEN_W-1:0] cfg_wdata,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [kwch_pkg::SYM_W-1:0] symbol,
    input  logic                       end_of_sequence,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [kwch_pkg::CRC_W-1:0] window_hash,
    output logic                       last_of_sequence
);

    kwch_pkg::kwch_cmd_t cmd;
    kwch_pkg::kwch_sts_t sts;

    kwch_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    kwch_dp u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_wdata        (cfg_wdata),
        .symbol           (symbol),
        .end_of_sequence  (end_of_sequence),
        .window_hash      (window_hash),
        .last_of_sequence (last_of_sequence),
        .cmd              (cmd),
        .sts              (sts)
    );

endmodule
